@@ rtl/core/tefc_pkg.sv @@
package tefc_pkg;

    localparam int MAX_TREES    = 16;
    localparam int MAX_NODES    = 256;
    localparam int MAX_FEATURES = 16;
    localparam int MAX_CLASSES  = 4;
    localparam int MAX_DEPTH    = 32;

    localparam int TW  = $clog2(MAX_TREES);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int FW  = $clog2(MAX_FEATURES);
    localparam int CW  = $clog2(MAX_CLASSES);
    localparam int SW  = TW + NW;
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int ACW = 42;

    localparam logic [2:0] KIND_NODE    = 3'd0;
    localparam logic [2:0] KIND_DELTA   = 3'd1;
    localparam logic [2:0] KIND_FEATURE = 3'd2;
    localparam logic [2:0] KIND_EXPLAIN = 3'd3;
    localparam logic [2:0] KIND_BIAS    = 3'd4;

    localparam logic [1:0] REG_CLASS   = 2'd0;
    localparam logic [1:0] REG_TREE    = 2'd1;
    localparam logic [1:0] REG_FEATURE = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         tree;
        logic [7:0]         node;
        logic [7:0]         left_child;
        logic [7:0]         right_child;
        logic [3:0]         feature_index;
        logic signed [31:0] threshold;
        logic [1:0]         class_index;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               is_bias;
        logic [3:0]         feature_index_res;
        logic [1:0]         class_index_res;
        logic signed [31:0] contribution;
        logic               depth_overflow;
        logic               last;
    } t_out;

    typedef struct packed {
        logic             start;
        logic signed [ACW-1:0] dividend;
        logic [4:0]       divisor;
    } t_div_req;

endpackage

@@ rtl/core/tefc_div.sv @@
module tefc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tefc_pkg::t_div_req                 i_req,
    output logic                               o_done,
    output logic signed [31:0]                 o_quot
);
    localparam int W = tefc_pkg::ACW;

    logic [W-1:0]   r_rem_n, n_rem_n;
    logic [W-1:0]   r_q, n_q;
    logic [W-1:0]   r_num, n_num;
    logic [4:0]     r_d;
    logic           r_neg;
    logic [5:0]     r_cnt, n_cnt;
    logic           r_busy;
    logic [W-1:0]   shifted;
    logic           fits;
    logic [W-1:0]   mag;
    logic signed [W:0] sq;

    always_comb begin
        shifted = {r_rem_n[W-2:0], r_num[W-1]};
        fits    = shifted >= {{(W-5){1'b0}}, r_d};
        n_rem_n = fits ? shifted - {{(W-5){1'b0}}, r_d} : shifted;
        n_q     = {r_q[W-2:0], fits};
        n_num   = {r_num[W-2:0], 1'b0};
        n_cnt   = r_cnt - 6'd1;
        mag     = i_req.dividend[W-1] ? W'(-i_req.dividend) : W'(i_req.dividend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_num   <= mag;
                r_rem_n <= '0;
                r_q     <= '0;
                r_d     <= i_req.divisor;
                r_neg   <= i_req.dividend[W-1];
                r_cnt   <= 6'(W);
            end else if (r_busy) begin
                r_rem_n <= n_rem_n;
                r_q     <= n_q;
                r_num   <= n_num;
                r_cnt   <= n_cnt;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        sq = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        if (sq > $signed((W+1)'(32'sh7fffffff)))
            o_quot = 32'sh7fffffff;
        else if (sq < -$signed((W+1)'(33'h080000000)))
            o_quot = 32'sh80000000;
        else
            o_quot = sq[31:0];
    end
endmodule

@@ rtl/core/tree_ensemble_feature_contribution_unit.sv @@
// writes and unknown kinds take the accept cycle only, busy stays low
// explain: clear all 64 sums, then per tree a read and step per node visited and a read
// and write per class per step taken (up to 32 steps), then each sum divided by the tree
// count in the shared 42-step divider. bias: per class, root deltas summed over trees, divided
// one item at a time, the next accepted in the cycle of the final result strobe; no stalls
// synchronous active-low reset clears control and configuration; tables keep contents
module tree_ensemble_feature_contribution_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tefc_pkg::t_in         i_item,
    output logic                  o_strobe,
    output tefc_pkg::t_out        o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int SW  = tefc_pkg::SW;
    localparam int ACW = tefc_pkg::ACW;
    localparam int FW  = tefc_pkg::FW;
    localparam int CW  = tefc_pkg::CW;
    localparam int NW  = tefc_pkg::NW;
    localparam int TW  = tefc_pkg::TW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_STEP   = 4'd3;
    localparam logic [3:0] S_ACC_RD = 4'd4;
    localparam logic [3:0] S_ACC_WR = 4'd5;
    localparam logic [3:0] S_OUT_RD = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_BIAS_RD = 4'd8;
    localparam logic [3:0] S_BIAS_AC = 4'd9;

    // memories
    logic [7:0]        m_left  [tefc_pkg::MAX_TREES*tefc_pkg::MAX_NODES];
    logic [7:0]        m_right [tefc_pkg::MAX_TREES*tefc_pkg::MAX_NODES];
    logic [FW-1:0]     m_split [tefc_pkg::MAX_TREES*tefc_pkg::MAX_NODES];
    logic signed [31:0] m_thr  [tefc_pkg::MAX_TREES*tefc_pkg::MAX_NODES];
    logic signed [31:0] m_delta [tefc_pkg::MAX_TREES*tefc_pkg::MAX_NODES*tefc_pkg::MAX_CLASSES];
    logic signed [31:0] r_feat [tefc_pkg::MAX_FEATURES];
    logic signed [ACW-1:0] m_acc [tefc_pkg::MAX_FEATURES*tefc_pkg::MAX_CLASSES];

    logic [2:0] r_class_cnt;
    logic [4:0] r_tree_cnt;
    logic [4:0] r_feat_cnt;

    logic [3:0]   r_state;
    logic         r_ovf, r_bias;
    logic [TW:0]  r_tree;
    logic [NW-1:0] r_node;
    logic [5:0]   r_steps;
    logic [FW-1:0] r_f;
    logic [CW:0]  r_c;
    logic [FW+CW-1:0] r_idx;
    logic signed [ACW-1:0] r_sum;

    logic [7:0]        rd_l, rd_r;
    logic [FW-1:0]     rd_sf;
    logic signed [31:0] rd_thr, rd_delta;
    logic signed [ACW-1:0] rd_acc;

    logic [SW-1:0]     node_addr;
    logic [SW+CW-1:0]  delta_addr;
    logic [FW+CW-1:0]  acc_addr;

    tefc_pkg::t_div_req div_req;
    logic               div_done;
    logic signed [31:0] div_q;

    logic [2:0] wr_reg;
    logic [4:0] wv5;
    logic [2:0] wv3;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wv3 = pwdata[2:0];
    assign wv5 = pwdata[4:0];
    assign wr_reg = {1'b0, paddr[3:2]};

    always_comb begin
        unique case (paddr[3:2])
            tefc_pkg::REG_CLASS:   prdata = {29'd0, r_class_cnt};
            tefc_pkg::REG_TREE:    prdata = {27'd0, r_tree_cnt};
            tefc_pkg::REG_FEATURE: prdata = {27'd0, r_feat_cnt};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_cnt <= 3'd1;
            r_tree_cnt  <= 5'd1;
            r_feat_cnt  <= 5'd1;
        end else if (cfg_wr && wr_reg[2] == 1'b0) begin
            unique case (wr_reg[1:0])
                tefc_pkg::REG_CLASS:
                    r_class_cnt <= (wv3 == 3'd0) ? 3'd1 :
                                   (wv3 > 3'(tefc_pkg::MAX_CLASSES)) ?
                                   3'(tefc_pkg::MAX_CLASSES) : wv3;
                tefc_pkg::REG_TREE:
                    r_tree_cnt  <= (wv5 == 5'd0) ? 5'd1 :
                                   (wv5 > 5'(tefc_pkg::MAX_TREES)) ?
                                   5'(tefc_pkg::MAX_TREES) : wv5;
                tefc_pkg::REG_FEATURE:
                    r_feat_cnt  <= (wv5 == 5'd0) ? 5'd1 :
                                   (wv5 > 5'(tefc_pkg::MAX_FEATURES)) ?
                                   5'(tefc_pkg::MAX_FEATURES) : wv5;
                default: ;
            endcase
        end
    end

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);

    // table writes and reads
    always_comb begin
        node_addr  = {r_tree[TW-1:0], r_node};
        delta_addr = {r_tree[TW-1:0], r_node, r_c[CW-1:0]};
        acc_addr   = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == tefc_pkg::KIND_NODE) begin
            m_left [{i_item.tree, i_item.node}] <= i_item.left_child;
            m_right[{i_item.tree, i_item.node}] <= i_item.right_child;
            m_split[{i_item.tree, i_item.node}] <= i_item.feature_index;
            m_thr  [{i_item.tree, i_item.node}] <= i_item.threshold;
        end
        rd_l   <= m_left [node_addr];
        rd_r   <= m_right[node_addr];
        rd_sf  <= m_split[node_addr];
        rd_thr <= m_thr  [node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == tefc_pkg::KIND_DELTA)
            m_delta[{i_item.tree, i_item.node, i_item.class_index}] <= i_item.value;
        rd_delta <= m_delta[delta_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == tefc_pkg::KIND_FEATURE)
            r_feat[i_item.feature_index] <= i_item.value;
    end

    logic signed [ACW-1:0] acc_wdata;
    logic                  acc_we;
    always_ff @(posedge i_clk) begin
        if (acc_we)
            m_acc[acc_addr] <= acc_wdata;
        rd_acc <= m_acc[acc_addr];
    end

    // walk helpers
    logic signed [31:0]    fv;
    logic                  go_left;
    logic [7:0]            nxt;
    logic signed [ACW:0]   add_s;
    logic signed [ACW-1:0] add_sat;
    logic signed [ACW-1:0] acc_max, acc_min;

    assign acc_max = {1'b0, {(ACW-1){1'b1}}};
    assign acc_min = {1'b1, {(ACW-1){1'b0}}};

    always_comb begin
        fv      = r_feat[rd_sf];
        go_left = fv <= rd_thr;
        nxt     = go_left ? rd_l : rd_r;
        add_s   = {rd_acc[ACW-1], rd_acc} + (ACW+1)'(rd_delta);
        if (add_s > $signed({1'b0, acc_max}))
            add_sat = acc_max;
        else if (add_s < $signed({1'b1, acc_min}))
            add_sat = acc_min;
        else
            add_sat = add_s[ACW-1:0];
    end

    logic last_tree, last_class, last_feat;
    assign last_tree  = (r_tree + 1'b1) == (TW+1)'(r_tree_cnt);
    assign last_class = (r_c + 1'b1) == (CW+1)'(r_class_cnt);
    assign last_feat  = (5'(r_f) + 5'd1) == r_feat_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tree <= '0;
                        r_node <= '0;
                        r_steps <= '0;
                        r_c    <= '0;
                        r_f    <= '0;
                        r_idx  <= '0;
                        r_ovf  <= 1'b0;
                        r_sum  <= '0;
                        if (i_item.kind == tefc_pkg::KIND_EXPLAIN) begin
                            r_bias  <= 1'b0;
                            r_state <= S_CLEAR;
                        end else if (i_item.kind == tefc_pkg::KIND_BIAS) begin
                            r_bias  <= 1'b1;
                            r_state <= S_BIAS_RD;
                        end
                    end
                end
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (&r_idx)
                        r_state <= S_RD;
                end
                S_RD: r_state <= S_STEP;
                S_STEP: begin
                    if ((rd_l == 8'd0 && rd_r == 8'd0) || r_steps == 6'(tefc_pkg::MAX_DEPTH)) begin
                        if (!(rd_l == 8'd0 && rd_r == 8'd0))
                            r_ovf <= 1'b1;
                        r_node  <= '0;
                        r_steps <= '0;
                        r_tree  <= r_tree + 1'b1;
                        if (last_tree) begin
                            r_f <= '0;
                            r_c <= '0;
                            r_idx <= '0;
                            r_state <= S_OUT_RD;
                        end else
                            r_state <= S_RD;
                    end else begin
                        r_node  <= nxt;
                        r_steps <= r_steps + 1'b1;
                        r_f     <= rd_sf;
                        r_c     <= '0;
                        r_idx   <= {rd_sf, {CW{1'b0}}};
                        r_state <= S_ACC_RD;
                    end
                end
                S_ACC_RD: r_state <= S_ACC_WR;
                S_ACC_WR: begin
                    r_c   <= r_c + 1'b1;
                    r_idx <= r_idx + 1'b1;
                    if (last_class)
                        r_state <= S_RD;
                    else
                        r_state <= S_ACC_RD;
                end
                S_OUT_RD: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        o_strobe <= 1'b1;
                        o_result.is_bias <= r_bias;
                        o_result.feature_index_res <= r_bias ? 4'd0 : r_f;
                        o_result.class_index_res <= r_c[CW-1:0];
                        o_result.contribution <= div_q;
                        o_result.depth_overflow <= r_bias ? 1'b0 : r_ovf;
                        o_result.last <= last_class && (r_bias || last_feat);
                        r_c <= r_c + 1'b1;
                        r_idx <= r_idx + 1'b1;
                        r_tree <= '0;
                        r_sum <= '0;
                        if (last_class) begin
                            r_c <= '0;
                            r_f <= r_f + 1'b1;
                            r_idx <= {r_f + 1'b1, {CW{1'b0}}};
                        end
                        if (last_class && (r_bias || last_feat))
                            r_state <= S_IDLE;
                        else
                            r_state <= r_bias ? S_BIAS_RD : S_OUT_RD;
                    end
                end
                S_BIAS_RD: r_state <= S_BIAS_AC;
                S_BIAS_AC: begin
                    r_sum  <= r_sum + ACW'(rd_delta);
                    r_tree <= r_tree + 1'b1;
                    r_state <= last_tree ? S_DIV : S_BIAS_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic r_div_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_div_go <= 1'b0;
        else
            r_div_go <= (r_state == S_OUT_RD) ||
                        (r_state == S_BIAS_AC && last_tree);
    end

    always_comb begin
        acc_we    = (r_state == S_CLEAR) || (r_state == S_ACC_WR);
        acc_wdata = (r_state == S_CLEAR) ? '0 : add_sat;
        div_req.start    = r_div_go;
        div_req.dividend = r_bias ? r_sum : rd_acc;
        div_req.divisor  = r_tree_cnt;
    end

    tefc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );
endmodule

@@ test/tree_ensemble_feature_contribution_unit_tb.sv @@
module tree_ensemble_feature_contribution_unit_tb;
    localparam int MAX_TREES    = tefc_pkg::MAX_TREES;
    localparam int MAX_NODES    = tefc_pkg::MAX_NODES;
    localparam int MAX_FEATURES = tefc_pkg::MAX_FEATURES;
    localparam int MAX_CLASSES  = tefc_pkg::MAX_CLASSES;
    localparam int MAX_DEPTH    = tefc_pkg::MAX_DEPTH;

    localparam logic [2:0] KIND_NODE    = tefc_pkg::KIND_NODE;
    localparam logic [2:0] KIND_DELTA   = tefc_pkg::KIND_DELTA;
    localparam logic [2:0] KIND_FEATURE = tefc_pkg::KIND_FEATURE;
    localparam logic [2:0] KIND_EXPLAIN = tefc_pkg::KIND_EXPLAIN;
    localparam logic [2:0] KIND_BIAS    = tefc_pkg::KIND_BIAS;

    localparam logic [3:0] ADDR_CLASS   = 4'(tefc_pkg::REG_CLASS) << 2;
    localparam logic [3:0] ADDR_TREE    = 4'(tefc_pkg::REG_TREE) << 2;
    localparam logic [3:0] ADDR_FEATURE = 4'(tefc_pkg::REG_FEATURE) << 2;
    localparam longint ACC_HI = 64'sd2199023255551;
    localparam longint ACC_LO = -ACC_HI - 1;

    class contribution_board;
        logic [7:0]         lt [MAX_TREES*MAX_NODES];
        logic [7:0]         rt [MAX_TREES*MAX_NODES];
        logic [3:0]         sf [MAX_TREES*MAX_NODES];
        logic signed [31:0] th [MAX_TREES*MAX_NODES];
        logic signed [31:0] dl [MAX_TREES*MAX_NODES*MAX_CLASSES];
        logic signed [31:0] fv [MAX_FEATURES];
        longint             sums [MAX_FEATURES*MAX_CLASSES];
        int                 n_cls, n_tree, n_feat;
        tefc_pkg::t_out     pending [$];
        int                 errors;

        function void set_reg(logic [3:0] addr, logic [31:0] v);
            int x;
            int hi;
            hi = (addr == ADDR_CLASS) ? MAX_CLASSES :
                 (addr == ADDR_TREE) ? MAX_TREES : MAX_FEATURES;
            x = (addr == ADDR_CLASS) ? int'(v[2:0]) : int'(v[4:0]);
            if (x < 1) x = 1;
            if (x > hi) x = hi;
            if (addr == ADDR_CLASS) n_cls = x;
            else if (addr == ADDR_TREE) n_tree = x;
            else n_feat = x;
        endfunction

        function logic signed [31:0] average(longint s);
            longint q;
            q = s / longint'(n_tree);
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            return q[31:0];
        endfunction

        function bit walk(int t);
            int n, steps, nx, f, s;
            logic signed [31:0] v;
            longint a;
            n = 0;
            steps = 0;
            forever begin
                s = t*MAX_NODES + n;
                if (lt[s] == 8'd0 && rt[s] == 8'd0) return 1'b0;
                if (steps >= MAX_DEPTH) return 1'b1;
                f = int'(sf[s]);
                v = fv[f];
                nx = (v <= th[s]) ? int'(lt[s]) : int'(rt[s]);
                n = nx;
                steps++;
                for (int c = 0; c < n_cls; c++) begin
                    a = sums[f*MAX_CLASSES+c] + longint'(dl[(t*MAX_NODES+n)*MAX_CLASSES+c]);
                    if (a > ACC_HI) a = ACC_HI;
                    if (a < ACC_LO) a = ACC_LO;
                    sums[f*MAX_CLASSES+c] = a;
                end
            end
        endfunction

        function void note_item(tefc_pkg::t_in it);
            tefc_pkg::t_out r;
            bit ovf;
            longint s;
            int slot;
            slot = int'(it.tree)*MAX_NODES + int'(it.node);
            case (it.kind)
                KIND_NODE: begin
                    lt[slot] = it.left_child;
                    rt[slot] = it.right_child;
                    sf[slot] = it.feature_index;
                    th[slot] = it.threshold;
                end
                KIND_DELTA: dl[slot*MAX_CLASSES+int'(it.class_index)] = it.value;
                KIND_FEATURE: fv[it.feature_index] = it.value;
                KIND_EXPLAIN: begin
                    ovf = 1'b0;
                    foreach (sums[i]) sums[i] = 0;
                    for (int t = 0; t < n_tree; t++) if (walk(t)) ovf = 1'b1;
                    for (int f = 0; f < n_feat; f++)
                        for (int c = 0; c < n_cls; c++) begin
                            r = '0;
                            r.is_bias = 1'b0;
                            r.feature_index_res = 4'(f);
                            r.class_index_res = 2'(c);
                            r.contribution = average(sums[f*MAX_CLASSES+c]);
                            r.depth_overflow = ovf;
                            r.last = (f == n_feat-1) && (c == n_cls-1);
                            pending.push_back(r);
                        end
                end
                KIND_BIAS: begin
                    for (int c = 0; c < n_cls; c++) begin
                        s = 0;
                        for (int t = 0; t < n_tree; t++)
                            s += longint'(dl[t*MAX_NODES*MAX_CLASSES+c]);
                        r = '0;
                        r.is_bias = 1'b1;
                        r.class_index_res = 2'(c);
                        r.contribution = average(s);
                        r.last = (c == n_cls-1);
                        pending.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(tefc_pkg::t_out got);
            tefc_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                $display("%0t mismatch expected %h actual %h", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk, i_rst_n, start, busy, o_strobe;
    tefc_pkg::t_in   i_item;
    tefc_pkg::t_out  o_result;
    logic            psel, penable, pwrite, pready;
    logic [3:0]      paddr;
    logic [31:0]     pwdata, prdata;

    contribution_board board;
    bit start_on;

    tree_ensemble_feature_contribution_unit u_dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_strobe) board.check_result(o_result);

    task automatic idle_start();
        if (start_on) begin
            start <= 1'b0;
            start_on = 1'b0;
        end
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if (n > 0) begin
            idle_start();
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(tefc_pkg::t_in it);
        if (!start_on) begin
            start <= 1'b1;
            start_on = 1'b1;
        end
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
        if ($urandom_range(0, 2) == 0) gap();
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        idle_start();
        while ((board.pending.size() != 0 || busy) && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [3:0] a, logic [31:0] d);
        idle_start();
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        board.set_reg(a, d);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    function automatic tefc_pkg::t_in blank(logic [2:0] k);
        tefc_pkg::t_in it;
        it = '0;
        it.kind = k;
        it.threshold = $urandom;
        it.value = $urandom;
        it.tree = 4'($urandom);
        it.node = 8'($urandom);
        it.feature_index = 4'($urandom);
        it.class_index = 2'($urandom);
        it.left_child = 8'($urandom);
        it.right_child = 8'($urandom);
        return it;
    endfunction

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 200000)) - 32'd100000);
            default: return $urandom;
        endcase
    endfunction

    task automatic node_w(int t, int n, int l, int r, int f, logic signed [31:0] th);
        tefc_pkg::t_in it;
        it = blank(KIND_NODE);
        it.tree = 4'(t); it.node = 8'(n); it.left_child = 8'(l); it.right_child = 8'(r);
        it.feature_index = 4'(f); it.threshold = th;
        send(it);
    endtask

    task automatic delta_w(int t, int n, int c, logic signed [31:0] v);
        tefc_pkg::t_in it;
        it = blank(KIND_DELTA);
        it.tree = 4'(t); it.node = 8'(n); it.class_index = 2'(c); it.value = v;
        send(it);
    endtask

    task automatic feat_w(int f, logic signed [31:0] v);
        tefc_pkg::t_in it;
        it = blank(KIND_FEATURE);
        it.feature_index = 4'(f); it.value = v;
        send(it);
    endtask

    // a tree of nodes 0..k: node i splits to 2i+1/2i+2 within k, others leaves;
    // a chain tree loops to force the depth limit
    task automatic build_tree(int t, int k, bit chain);
        int l, r;
        for (int i = 0; i <= k; i++) begin
            if (chain && i < k) begin
                l = i + 1; r = (i == k-1) ? 1 : i + 1;
            end else begin
                l = (2*i+1 <= k) ? 2*i+1 : 0;
                r = (2*i+2 <= k) ? 2*i+2 : 0;
                if (l != 0 && r == 0) r = l;
            end
            if (chain && i == k) begin l = 1; r = 1; end
            node_w(t, i, l, r, int'($urandom_range(0, 15)), rnd_val());
            for (int c = 0; c < MAX_CLASSES; c++) delta_w(t, i, c, rnd_val());
        end
    endtask

    task automatic explain();
        send(blank(KIND_EXPLAIN));
    endtask

    initial begin
        board = new();
        board.errors = 0;
        board.n_cls = 1; board.n_tree = 1; board.n_feat = 1;
        start_on = 1'b0;
        i_rst_n = 0; start = 0; i_item = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every feature, every tree loaded before use
        for (int f = 0; f < MAX_FEATURES; f++) feat_w(f, (f % 2) ? 32'sh7fffffff : 32'sh80000000);
        build_tree(0, 2, 0);
        explain();
        send(blank(KIND_BIAS));
        send(blank(3'd5));
        send(blank(3'd7));
        settle();

        reg_write(ADDR_CLASS, 32'd4);
        reg_write(ADDR_TREE, 32'd2);
        reg_write(ADDR_FEATURE, 32'd16);
        build_tree(1, 4, 1);
        explain();
        send(blank(KIND_BIAS));
        settle();

        for (int t = 2; t < MAX_TREES; t++) build_tree(t, int'($urandom_range(0, 2)), 0);
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(ADDR_CLASS, 0); reg_write(ADDR_TREE, 0);
                    reg_write(ADDR_FEATURE, 0); end
                1: begin reg_write(ADDR_CLASS, 7); reg_write(ADDR_TREE, 31);
                    reg_write(ADDR_FEATURE, 31); end
                default: begin
                    reg_write(ADDR_CLASS, $urandom_range(0, 7));
                    reg_write(ADDR_TREE, $urandom_range(0, 31));
                    reg_write(ADDR_FEATURE, $urandom_range(0, 31));
                end
            endcase
            for (int i = 0; i < 16; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: feat_w(int'($urandom_range(0, 15)), rnd_val());
                    3: begin
                        int t;
                        t = int'($urandom_range(0, 15));
                        delta_w(t, 0, int'($urandom_range(0, 3)), rnd_val());
                    end
                    4: begin
                        int t;
                        t = int'($urandom_range(2, 15));
                        node_w(t, 0, 0, 0, int'($urandom_range(0, 15)), rnd_val());
                    end
                    5: send(blank(3'($urandom_range(5, 7))));
                    6: send(blank(KIND_BIAS));
                    default: explain();
                endcase
            end
            if (ph == 3)
                build_tree(int'($urandom_range(2, 15)), int'($urandom_range(1, 4)), 0);
            settle();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
